// ===== rtl/fpa_pkg.sv =====
// package for the fit policy partition allocator
// item types, codes, command and status structs; no dependencies
package fpa_pkg;

  localparam int PARTS_DEFAULT = 64;
  localparam int CFG_DATA_W = 7;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_NEXT = 2'd1;
  localparam logic [1:0] MODE_BEST = 2'd2;
  localparam logic [1:0] MODE_WORST = 2'd3;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_PART_COUNT = 1'b1;

  localparam logic [1:0] FIT_MODE_RESET = MODE_FIRST;
  localparam logic [6:0] PART_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] part_index;
    logic [15:0] amount;
  } req_t;

  typedef struct packed {
    logic granted;
    logic [5:0] chosen_index;
    logic [15:0] held_amount;
  } rsp_t;

  typedef struct packed {
    logic take;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// ===== rtl/fit_policy_partition_allocator.sv =====
// top level: partition allocator with first, next, best and worst fit placement
// allocate: scan of the live partitions, a drain state, then the result state
// live is partition_count held to 1..PARTS; one size read per cycle
// query: straight to the result state; load and clear complete when taken
// one item in flight; a waiting result does not block loads or clears
// rst (synchronous) frees all partitions, zeroes the next-fit position, fit_mode 0, count 64
module fit_policy_partition_allocator #(
  parameter int PARTS = fpa_pkg::PARTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  fpa_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output fpa_pkg::rsp_t               rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_kind  (req.kind),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fpa_datapath #(
    .PARTS (PARTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!rsp_valid || rsp_ready))
    else $error("result written over an untaken result");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp_valid)
    else $error("finished item not presented");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !req_ready)
    else $error("item accepted during scan");

endmodule

// ===== rtl/fpa_ctrl.sv =====
// controller state machine for the partition allocator
// depends on fpa_pkg; drives fpa_datapath through cmd_t and reads sts_t
module fpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [1:0]    req_kind,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fpa_pkg::cmd_t cmd,
  input  fpa_pkg::sts_t sts
);
  import fpa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign req_ready = (state == ST_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    cmd.take = 1'b0;
    cmd.scan = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take = 1'b1;
          unique case (req_kind)
            KIND_ALLOC: state_next = ST_SCAN;
            KIND_QUERY: state_next = ST_RESULT;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/fpa_datapath.sv =====
// datapath: partition tables, config registers, scan and pick logic, result register
// depends on fpa_pkg; commanded by fpa_ctrl
module fpa_datapath #(
  parameter int PARTS = fpa_pkg::PARTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  fpa_pkg::req_t               req,
  input  fpa_pkg::cmd_t               cmd,
  output fpa_pkg::sts_t               sts,
  output fpa_pkg::rsp_t               rsp
);
  import fpa_pkg::*;

  localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int CNT_W = IDX_W + 1;

  logic [15:0]      size_mem [PARTS];
  logic [15:0]      alloc_mem [PARTS];
  logic [PARTS-1:0] used;

  logic [1:0]       fit_mode;
  logic [6:0]       part_count;
  logic [IDX_W-1:0] next_pos;

  logic [1:0]       kind_q;
  logic [5:0]       idx_q;
  logic             in_range_q;
  logic [15:0]      amount_q;
  logic [15:0]      alloc_q;
  logic             qused_q;

  logic [IDX_W-1:0] scan_addr;
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_valid;
  logic [15:0]      size_q;
  logic             rused_q;
  logic [IDX_W-1:0] rd_idx;

  logic             pick_valid;
  logic [IDX_W-1:0] pick_idx;
  logic [15:0]      pick_size;

  logic [8:0]       count_ext;
  logic [8:0]       live_ext;
  logic [CNT_W-1:0] live;
  logic             in_range;
  logic [IDX_W-1:0] in_addr;
  logic [IDX_W-1:0] start_addr;
  logic [CNT_W-1:0] addr_inc;
  logic [CNT_W-1:0] pick_inc;
  logic             hit;
  logic             better;
  logic [IDX_W+5:0] pick_wide;
  logic             commit;

  assign count_ext = {2'b00, part_count};
  always_comb begin
    if (part_count == 7'd0) begin
      live_ext = 9'd1;
    end else if (count_ext > 9'(PARTS)) begin
      live_ext = 9'(PARTS);
    end else begin
      live_ext = count_ext;
    end
  end
  assign live = live_ext[CNT_W-1:0];

  assign in_range = {3'b000, req.part_index} < 9'(PARTS);
  assign in_addr = IDX_W'({3'b000, req.part_index});

  assign start_addr = (fit_mode == MODE_NEXT && {1'b0, next_pos} < live) ? next_pos : '0;
  assign addr_inc = {1'b0, scan_addr} + CNT_W'(1);
  assign pick_inc = {1'b0, pick_idx} + CNT_W'(1);

  assign sts.scan_last = (scan_cnt == live - CNT_W'(1));

  assign hit = rd_valid && !rused_q && (amount_q <= size_q);
  assign better = !pick_valid ||
                  (fit_mode == MODE_BEST && size_q < pick_size) ||
                  (fit_mode == MODE_WORST && size_q > pick_size);

  assign commit = cmd.finish && kind_q == KIND_ALLOC && pick_valid;
  assign pick_wide = {6'b000000, pick_idx};

  always_ff @(posedge clk) begin
    if (cmd.take && req.kind == KIND_LOAD && in_range) begin
      size_mem[in_addr] <= req.amount;
    end
    if (cmd.scan) begin
      size_q <= size_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      alloc_mem[pick_idx] <= amount_q;
    end
    if (cmd.take && req.kind == KIND_QUERY) begin
      alloc_q <= alloc_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= FIT_MODE_RESET;
      part_count <= PART_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_MODE: fit_mode <= cfg_data[1:0];
        CFG_PART_COUNT: part_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      next_pos <= '0;
      rd_valid <= 1'b0;
      pick_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      if (cmd.take) begin
        unique case (req.kind)
          KIND_LOAD: begin
            if (in_range) begin
              used[in_addr] <= 1'b0;
            end
          end
          KIND_CLEAR: begin
            used <= '0;
            next_pos <= '0;
          end
          KIND_ALLOC: pick_valid <= 1'b0;
          default: ;
        endcase
      end
      if (hit && better) begin
        pick_valid <= 1'b1;
      end
      if (commit) begin
        used[pick_idx] <= 1'b1;
        if (fit_mode == MODE_NEXT) begin
          next_pos <= (pick_inc >= live) ? '0 : pick_inc[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q <= req.kind;
      idx_q <= req.part_index;
      in_range_q <= in_range;
      amount_q <= req.amount;
      qused_q <= used[in_addr];
      scan_addr <= start_addr;
      scan_cnt <= '0;
    end else if (cmd.scan) begin
      scan_addr <= (addr_inc == live) ? '0 : addr_inc[IDX_W-1:0];
      scan_cnt <= scan_cnt + CNT_W'(1);
    end
    if (cmd.scan) begin
      rused_q <= used[scan_addr];
      rd_idx <= scan_addr;
    end
    if (hit && better) begin
      pick_idx <= rd_idx;
      pick_size <= size_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (kind_q == KIND_QUERY) begin
        rsp.granted <= in_range_q && qused_q;
        rsp.chosen_index <= idx_q;
        rsp.held_amount <= (in_range_q && qused_q) ? alloc_q : 16'd0;
      end else begin
        rsp.granted <= pick_valid;
        rsp.chosen_index <= pick_valid ? pick_wide[5:0] : 6'd0;
        rsp.held_amount <= pick_valid ? amount_q : 16'd0;
      end
    end
  end

endmodule

// ===== verif/tb_fit_policy_partition_allocator.sv =====
// self-checking testbench for fit_policy_partition_allocator
// holds its own partition table to predict grants and query answers
// depends on fpa_pkg and the allocator rtl
module tb_fit_policy_partition_allocator;
  import fpa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_FIT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // partition table as the allocator should hold it
  bit [15:0] sz_table [64];
  bit in_use [64];
  bit [15:0] placed [64];
  int next_slot = 0;
  logic [1:0] fit_sel = FIT_MODE_RESET;
  logic [6:0] count_reg = PART_COUNT_RESET;

  req_t items_to_send [$];
  rsp_t answers_due [$];
  bit was_loaded [64];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_trigger = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  fit_policy_partition_allocator DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_of(logic [6:0] c);
    if (c == 0) return 1;
    if (c > 64) return 64;
    return c;
  endfunction

  function automatic int pick_partition(logic [15:0] want);
    int cnt;
    int start;
    int i;
    int pick;
    cnt = live_of(count_reg);
    pick = -1;
    case (fit_sel)
      MODE_FIRST: begin
        for (i = 0; i < cnt; i++)
          if (!in_use[i] && want <= sz_table[i]) return i;
      end
      MODE_NEXT: begin
        start = (next_slot < cnt) ? next_slot : 0;
        for (int k = 0; k < cnt; k++) begin
          i = (start + k) % cnt;
          if (!in_use[i] && want <= sz_table[i]) return i;
        end
      end
      default: begin
        for (i = 0; i < cnt; i++) begin
          if (in_use[i] || want > sz_table[i]) continue;
          if (pick < 0 ||
              (fit_sel == MODE_BEST && sz_table[i] < sz_table[pick]) ||
              (fit_sel == MODE_WORST && sz_table[i] > sz_table[pick]))
            pick = i;
        end
      end
    endcase
    return pick;
  endfunction

  function automatic void apply_request(req_t it);
    int c;
    rsp_t ans;
    ans = '0;
    case (it.kind)
      KIND_LOAD: begin
        sz_table[it.part_index] = it.amount;
        in_use[it.part_index] = 1'b0;
        placed[it.part_index] = '0;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < 64; i++) begin
          in_use[i] = 1'b0;
          placed[i] = '0;
        end
        next_slot = 0;
      end
      KIND_QUERY: begin
        ans.granted = in_use[it.part_index];
        ans.chosen_index = it.part_index;
        ans.held_amount = placed[it.part_index];
        answers_due.push_back(ans);
      end
      default: begin
        c = pick_partition(it.amount);
        if (c >= 0) begin
          in_use[c] = 1'b1;
          placed[c] = it.amount;
          if (fit_sel == MODE_NEXT) next_slot = (c + 1 >= live_of(count_reg)) ? 0 : c + 1;
          ans.granted = 1'b1;
          ans.chosen_index = c[5:0];
          ans.held_amount = it.amount;
        end
        answers_due.push_back(ans);
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) apply_request(req);
      if (!(req_valid && !req_ready)) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= items_to_send.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    rsp_t due;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result granted=%0d index=%0d amount=%0d", $time,
                   rsp.granted, rsp.chosen_index, rsp.held_amount);
        end else begin
          due = answers_due.pop_front();
          if (rsp.granted !== due.granted || rsp.chosen_index !== due.chosen_index ||
              rsp.held_amount !== due.held_amount) begin
            mismatches++;
            $display("%0t: mismatch expected granted=%0d index=%0d amount=%0d, got %0d %0d %0d",
                     $time, due.granted, due.chosen_index, due.held_amount,
                     rsp.granted, rsp.chosen_index, rsp.held_amount);
          end
        end
      end
      if (hold_trigger && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic queue_item(logic [1:0] k, int idx, int amt);
    req_t it;
    it.kind = k;
    it.part_index = idx[5:0];
    it.amount = amt[15:0];
    if (k == KIND_LOAD) was_loaded[idx] = 1'b1;
    items_to_send.push_back(it);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_FIT_MODE) fit_sel = val[1:0];
    else count_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every item is through, then let a full allocate scan pass
  task automatic settle();
    do @(negedge clk);
    while (items_to_send.size() != 0 || req_valid || answers_due.size() != 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic start_phase(logic [1:0] mode, logic [6:0] cnt, int idle, int stall);
    settle();
    write_reg(CFG_FIT_MODE, {5'd0, mode});
    write_reg(CFG_PART_COUNT, cnt);
    send_idle_pct <= idle;
    stall_pct <= stall;
  endtask

  function automatic int pick_size();
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(65535);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic int pick_request();
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(65535);
      default: return $urandom_range(400);
    endcase
  endfunction

  task automatic queue_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 7) queue_item(KIND_LOAD, $urandom_range(63), pick_size());
      else if (r < 11) queue_item(KIND_CLEAR, $urandom_range(63), $urandom_range(65535));
      else if (r < 27) queue_item(KIND_QUERY, $urandom_range(63), $urandom_range(65535));
      else queue_item(KIND_ALLOC, $urandom_range(63), pick_request());
    end
  endtask

  initial begin
    static int send_prof [4] = '{0, 58, 0, 34};
    static int stall_prof [4] = '{0, 0, 58, 34};
    static int phase_count [12] = '{64, 127, 16, 1, 0, 64, 8, 127, 33, 64, 2, 64};
    int prof;
    int live;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // first fit basics, refusal, load on a used partition
    start_phase(MODE_FIRST, 7'd4, 0, 0);
    queue_item(KIND_QUERY, 63, 0);
    queue_item(KIND_LOAD, 0, 0);
    queue_item(KIND_LOAD, 1, 65535);
    queue_item(KIND_LOAD, 2, 100);
    queue_item(KIND_LOAD, 3, 100);
    queue_item(KIND_ALLOC, 0, 0);
    queue_item(KIND_ALLOC, 0, 65535);
    queue_item(KIND_ALLOC, 0, 50);
    queue_item(KIND_ALLOC, 0, 50);
    queue_item(KIND_ALLOC, 0, 1);
    queue_item(KIND_QUERY, 2, 0);
    queue_item(KIND_LOAD, 2, 100);
    queue_item(KIND_QUERY, 2, 0);
    queue_item(KIND_CLEAR, 0, 0);
    queue_item(KIND_QUERY, 1, 0);
    // best fit: zero-size partition, ties to lowest index
    start_phase(MODE_BEST, 7'd4, 0, 0);
    queue_item(KIND_ALLOC, 0, 0);
    queue_item(KIND_ALLOC, 0, 60);
    queue_item(KIND_ALLOC, 0, 60);
    // worst fit
    start_phase(MODE_WORST, 7'd4, 0, 0);
    queue_item(KIND_CLEAR, 0, 0);
    queue_item(KIND_ALLOC, 0, 0);
    queue_item(KIND_ALLOC, 0, 10);
    // next fit, then a count below the saved position
    start_phase(MODE_NEXT, 7'd4, 0, 0);
    queue_item(KIND_CLEAR, 0, 0);
    queue_item(KIND_ALLOC, 0, 0);
    queue_item(KIND_ALLOC, 0, 0);
    queue_item(KIND_ALLOC, 0, 0);
    start_phase(MODE_NEXT, 7'd0, 0, 0);
    queue_item(KIND_LOAD, 0, 500);
    queue_item(KIND_ALLOC, 0, 5);
    queue_item(KIND_ALLOC, 0, 5);

    for (int p = 0; p < 12; p++) begin
      prof = (p + p / 4) % 4;
      start_phase(p[1:0], phase_count[p][6:0], send_prof[prof], stall_prof[prof]);
      if (p == 5) hold_trigger <= 1'b1;
      live = live_of(phase_count[p][6:0]);
      for (int i = 0; i < live; i++)
        if (!was_loaded[i]) queue_item(KIND_LOAD, i, pick_size());
      queue_random(75);
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_fit_policy_partition_allocator: clean");
    end else begin
      $display("tb_fit_policy_partition_allocator: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_fit_policy_partition_allocator: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fpa_pkg.sv
rtl/fpa_ctrl.sv
rtl/fpa_datapath.sv
rtl/fit_policy_partition_allocator.sv
verif/tb_fit_policy_partition_allocator.sv
